@@ design/spjq_pkg.sv @@
package spjq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [4:0] LIMIT_RESET = 5'd16;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_REMOVE = 1'b1
	} spjq_action_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} spjq_status_t;

	typedef struct packed {
		spjq_action_t       action;
		logic [15:0]        job_id;
		logic [13:0]        job_size;
		logic [7:0]         job_user;
		logic signed [15:0] job_priority;
	} spjq_in_t;

	typedef struct packed {
		spjq_status_t       status;
		logic [15:0]        head_id;
		logic [13:0]        head_size;
		logic [7:0]         head_user;
		logic signed [15:0] head_priority;
		logic [4:0]         entry_count;
		logic               is_full;
		logic               is_empty;
	} spjq_out_t;

	typedef struct packed {
		logic [15:0]        id;
		logic [13:0]        size;
		logic [7:0]         user;
		logic signed [15:0] prio;
	} spjq_rec_t;

	typedef struct packed {
		logic start;
		logic out_free;
	} spjq_cmd_t;

	typedef struct packed {
		logic idle;
		logic done;
	} spjq_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUT,
		ST_INS,
		ST_HEAD,
		ST_SHIFT,
		ST_FIN
	} spjq_state_t;

endpackage

@@ design/spjq_engine.sv @@
module spjq_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  spjq_pkg::spjq_cmd_t            cmd,
	input  spjq_pkg::spjq_in_t             item,
	input  logic [spjq_pkg::CNT_W-1:0]     lim,
	output spjq_pkg::spjq_stat_t           stat,
	output spjq_pkg::spjq_out_t            result
);
	import spjq_pkg::*;

	spjq_rec_t   mem [CAPACITY];
	spjq_rec_t   rd_data_q;
	spjq_rec_t   wr_data;
	logic        rd_en;
	logic        wr_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;

	spjq_state_t state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [ADDR_W-1:0] k_q, k_d;
	spjq_rec_t   cur_q;
	spjq_out_t   res_q, res_d;
	logic        full_now;
	logic        keep_place;
	logic        shift_last;

	assign full_now   = (count_q >= lim);
	assign keep_place = ($signed(rd_data_q.prio) >= $signed(cur_q.prio));
	assign shift_last = ((CNT_W'(k_q) + CNT_W'(1)) == count_q);

	// synchronous store, one write and one read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.start) begin
					if (item.action == ACT_INSERT) begin
						if (full_now) begin
							state_d = ST_FIN;
						end else if (count_q == '0) begin
							state_d = ST_PUT;
						end else begin
							state_d = ST_INS;
						end
					end else begin
						if (count_q == '0) begin
							state_d = ST_FIN;
						end else begin
							state_d = ST_HEAD;
						end
					end
				end
			end
			ST_PUT: state_d = ST_FIN;
			ST_INS: begin
				if (keep_place) begin
					state_d = ST_FIN;
				end else if (k_q == ADDR_W'(1)) begin
					state_d = ST_PUT;
				end
			end
			ST_HEAD: begin
				if (count_q == CNT_W'(1)) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (shift_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (cmd.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory and datapath control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = k_q;
		wr_en   = 1'b0;
		wr_addr = k_q;
		wr_data = rd_data_q;
		k_d     = k_q;
		count_d = count_q;
		res_d   = res_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.start) begin
					res_d        = '0;
					res_d.status = STAT_DONE;
					if (item.action == ACT_INSERT) begin
						if (full_now) begin
							res_d.status = STAT_FULL;
						end else if (count_q == '0) begin
							k_d = '0;
						end else begin
							k_d     = count_q[ADDR_W-1:0];
							rd_en   = 1'b1;
							rd_addr = count_q[ADDR_W-1:0] - ADDR_W'(1);
						end
					end else begin
						if (count_q == '0) begin
							res_d.status = STAT_EMPTY;
						end else begin
							k_d     = '0;
							rd_en   = 1'b1;
							rd_addr = '0;
						end
					end
				end
			end
			ST_PUT: begin
				wr_en   = 1'b1;
				wr_data = cur_q;
				count_d = count_q + CNT_W'(1);
			end
			ST_INS: begin
				wr_en = 1'b1;
				if (keep_place) begin
					wr_data = cur_q;
					count_d = count_q + CNT_W'(1);
				end else begin
					k_d = k_q - ADDR_W'(1);
					if (k_q != ADDR_W'(1)) begin
						rd_en   = 1'b1;
						rd_addr = k_q - ADDR_W'(2);
					end
				end
			end
			ST_HEAD: begin
				res_d.head_id       = rd_data_q.id;
				res_d.head_size     = rd_data_q.size;
				res_d.head_user     = rd_data_q.user;
				res_d.head_priority = rd_data_q.prio;
				if (count_q == CNT_W'(1)) begin
					count_d = count_q - CNT_W'(1);
				end else begin
					k_d     = ADDR_W'(1);
					rd_en   = 1'b1;
					rd_addr = ADDR_W'(1);
				end
			end
			ST_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = k_q - ADDR_W'(1);
				if (shift_last) begin
					count_d = count_q - CNT_W'(1);
				end else begin
					k_d     = k_q + ADDR_W'(1);
					rd_en   = 1'b1;
					rd_addr = k_q + ADDR_W'(1);
				end
			end
			ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		k_q   <= k_d;
		res_q <= res_d;
		if (state_q == ST_IDLE && cmd.start) begin
			cur_q.id   <= item.job_id;
			cur_q.size <= item.job_size;
			cur_q.user <= item.job_user;
			cur_q.prio <= item.job_priority;
		end
	end

	assign stat.idle = (state_q == ST_IDLE);
	assign stat.done = (state_q == ST_FIN) && cmd.out_free;

	always_comb begin
		result             = res_q;
		result.entry_count = 5'(count_q);
		result.is_full     = full_now;
		result.is_empty    = (count_q == '0);
	end

endmodule

@@ design/sorted_priority_job_queue_core.sv @@
// channel  | direction | handshake            | payload
// in       | to core   | in_valid / in_stall  | in_data (spjq_in_t)
// out      | from core | out_valid / out_stall| out_data (spjq_out_t)
// cfg      | to core   | cfg_wr_en            | cfg_wr_data (queue_limit)
//
// one transaction at a time; the sorted entries live in one memory with a
// registered read, one entry moved per cycle
// insert: each entry of lower priority is shifted up one place, then the new
// entry is written; remove: the head is read and the rest shifted down one place
// reset leaves the queue empty and queue_limit at 16; no clearing pass
// a finished result waits in the output register while the next transaction
// is taken; a result finished while that register is stalled holds in the core
module sorted_priority_job_queue_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  spjq_pkg::spjq_in_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output spjq_pkg::spjq_out_t out_data,
	input  logic                cfg_wr_en,
	input  logic [4:0]          cfg_wr_data
);
	import spjq_pkg::*;

	logic [4:0]       limit_q;
	logic [CNT_W-1:0] lim_eff;
	logic             out_valid_q;
	spjq_out_t        out_data_q;
	spjq_cmd_t        cmd;
	spjq_stat_t       stat;
	spjq_out_t        result;

	always_comb begin
		if (limit_q == 5'd0) begin
			lim_eff = CNT_W'(1);
		end else if (32'(limit_q) > CAPACITY) begin
			lim_eff = CNT_W'(CAPACITY);
		end else begin
			lim_eff = CNT_W'(limit_q);
		end
	end

	assign in_stall     = !stat.idle;
	assign cmd.start    = in_valid && !in_stall;
	assign cmd.out_free = !out_valid_q || !out_stall;

	spjq_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (in_data),
		.lim    (lim_eff),
		.stat   (stat),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (stat.done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ design/spjq_chk.sv @@
module spjq_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input spjq_pkg::spjq_out_t out_data
);
	import spjq_pkg::*;

	// one transaction in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("core took a second transaction while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.is_empty == (out_data.entry_count == 5'd0)))
		else $error("empty flag disagrees with entry count");

	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STAT_FULL |-> out_data.is_full)
		else $error("rejected insert without full flag");

	a_no_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != STAT_DONE |->
			out_data.head_id == 16'd0 && out_data.head_priority == 16'sd0)
		else $error("head fields set on a failed transaction");

endmodule

bind sorted_priority_job_queue_core spjq_chk u_spjq_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
